// File: sv/alfs_pkg.sv
// shared types and constants for the addressable led frame sender
`default_nettype none

package alfs_pkg;

    localparam int LED_COUNT = 16;
    localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    localparam logic [2:0] KIND_SET_ONE = 3'd0;
    localparam logic [2:0] KIND_SET_ALL = 3'd1;
    localparam logic [2:0] KIND_CLEAR   = 3'd2;
    localparam logic [2:0] KIND_SHOW    = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    localparam logic [2:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [2:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [2:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [2:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [2:0] CFG_LATCH     = 3'd4;

    localparam logic [7:0]  RST_ONE_HIGH  = 8'd38;
    localparam logic [7:0]  RST_ONE_LOW   = 8'd22;
    localparam logic [7:0]  RST_ZERO_HIGH = 8'd19;
    localparam logic [7:0]  RST_ZERO_LOW  = 8'd41;
    localparam logic [15:0] RST_LATCH     = 16'd2400;

    localparam logic [2:0] BIT_FIRST = 3'd7;

    // byte order on the line within one led
    localparam logic [1:0] COL_GREEN = 2'd0;
    localparam logic [1:0] COL_RED   = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    typedef logic [23:0] t_grb;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } t_phase;

    typedef enum logic {
        CTL_IDLE,
        CTL_EXEC
    } t_ctl;

    typedef struct packed {
        logic             wr_en;
        logic             fill_en;
        logic [LED_W-1:0] addr;
        t_grb             wdata;
    } t_store_cmd;

endpackage

`default_nettype wire

// File: sv/addressable_led_frame_sender.sv
// top level of the addressable led frame sender
`default_nettype none

// usage
// - command channel: i_kind, i_led, i_red, i_green, i_blue are taken at a
//   rising edge with start high and busy low
// - kinds: set one led, set all leds, clear the store, show a frame, or one
//   line tick; time on the serial line moves only with tick items
// - every item gives one result on o_data_line, o_busy_res, o_frame_done and
//   o_status, marked by o_valid for exactly one cycle; the receiver cannot
//   stall, so results are simply presented and dropped after that cycle
// - timing: the first step of an item reads the current led row from
//   the pixel store (registered read), the second updates the frame
//   state and store; the result shows in the cycle after that, while the
//   next item may already be accepted
// - busy stays high until an item has executed, so items never overlap
// - set all and clear take no sweep; the store keeps a fill value and a
//   valid bit per led row
// - config port: i_cfg_we, i_cfg_idx, i_cfg_data write the timing
//   registers directly; write only while the block is idle
// - reset (i_rst_n low, synchronous) empties the store to all zero, stops
//   any frame and loads the default timing values

module addressable_led_frame_sender
    import alfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_kind,
    input  wire logic [7:0]  i_led,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    output logic             o_valid,
    output logic             o_data_line,
    output logic             o_busy_res,
    output logic             o_frame_done,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    // timing registers
    logic [7:0]  r_one_high, r_one_low, r_zero_high, r_zero_low;
    logic [15:0] r_latch;

    // control and frame state
    t_ctl             r_ctl, n_ctl;
    t_phase           r_phase, n_phase;
    logic [15:0]      r_cnt, n_cnt;
    logic [LED_W-1:0] r_led_ptr, n_led_ptr;
    logic [1:0]       r_color, n_color;
    logic [2:0]       r_bit, n_bit;

    // captured item
    logic [2:0] r_kind, n_kind;
    logic [7:0] r_led, n_led;
    logic [7:0] r_red, n_red;
    logic [7:0] r_green, n_green;
    logic [7:0] r_blue, n_blue;

    // result registers
    logic       r_valid, n_valid;
    logic       r_line, n_line;
    logic       r_busy_res, n_busy_res;
    logic       r_done, n_done;
    logic [1:0] r_status, n_status;

    t_store_cmd  store_cmd;
    t_grb        row;
    logic [7:0]  cur_byte;
    logic        cur_bit;
    logic [15:0] cnt_inc;
    logic [7:0]  high_lim, low_lim;
    logic        led_ok, last_led, busy_now;

    alfs_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (store_cmd),
        .i_rd_addr (r_led_ptr),
        .o_rd_data (row)
    );

    always_comb begin
        case (r_color)
            COL_GREEN: cur_byte = row[23:16];
            COL_RED:   cur_byte = row[15:8];
            COL_BLUE:  cur_byte = row[7:0];
            default:   cur_byte = 8'd0;
        endcase
    end

    assign cur_bit  = cur_byte[r_bit];
    assign cnt_inc  = r_cnt + 16'd1;
    assign high_lim = cur_bit ? r_one_high : r_zero_high;
    assign low_lim  = cur_bit ? r_one_low : r_zero_low;
    assign led_ok   = {1'b0, r_led} < 9'(LED_COUNT);
    assign last_led = r_led_ptr == LED_W'(LED_COUNT - 1);
    assign busy_now = r_phase != PH_IDLE;

    // timing registers, written straight from the config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_high  <= RST_ONE_HIGH;
            r_one_low   <= RST_ONE_LOW;
            r_zero_high <= RST_ZERO_HIGH;
            r_zero_low  <= RST_ZERO_LOW;
            r_latch     <= RST_LATCH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ONE_HIGH:  r_one_high  <= i_cfg_data[7:0];
                CFG_ONE_LOW:   r_one_low   <= i_cfg_data[7:0];
                CFG_ZERO_HIGH: r_zero_high <= i_cfg_data[7:0];
                CFG_ZERO_LOW:  r_zero_low  <= i_cfg_data[7:0];
                CFG_LATCH:     r_latch     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= CTL_IDLE;
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_led_ptr <= '0;
            r_color   <= COL_GREEN;
            r_bit     <= BIT_FIRST;
            r_valid   <= 1'b0;
        end else begin
            r_ctl     <= n_ctl;
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_led_ptr <= n_led_ptr;
            r_color   <= n_color;
            r_bit     <= n_bit;
            r_valid   <= n_valid;
        end
    end

    // captured item and result payload
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_led      <= n_led;
        r_red      <= n_red;
        r_green    <= n_green;
        r_blue     <= n_blue;
        r_line     <= n_line;
        r_busy_res <= n_busy_res;
        r_done     <= n_done;
        r_status   <= n_status;
    end

    always_comb begin
        n_ctl      = r_ctl;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_led_ptr  = r_led_ptr;
        n_color    = r_color;
        n_bit      = r_bit;
        n_kind     = r_kind;
        n_led      = r_led;
        n_red      = r_red;
        n_green    = r_green;
        n_blue     = r_blue;
        n_valid    = 1'b0;
        n_line     = r_line;
        n_busy_res = r_busy_res;
        n_done     = r_done;
        n_status   = r_status;
        store_cmd  = '0;

        case (r_ctl)
            CTL_IDLE: begin
                // the store read of the current row runs in this cycle
                if (start) begin
                    n_ctl   = CTL_EXEC;
                    n_kind  = i_kind;
                    n_led   = i_led;
                    n_red   = i_red;
                    n_green = i_green;
                    n_blue  = i_blue;
                end
            end
            CTL_EXEC: begin
                n_ctl    = CTL_IDLE;
                n_valid  = 1'b1;
                n_done   = 1'b0;
                n_status = ST_OK;
                if (r_kind == KIND_TICK) begin
                    n_busy_res = busy_now;
                    n_line     = 1'b0;
                    case (r_phase)
                        PH_HIGH: begin
                            n_line = 1'b1;
                            n_cnt  = cnt_inc;
                            if (cnt_inc >= {8'd0, high_lim}) begin
                                n_phase = PH_LOW;
                                n_cnt   = '0;
                            end
                        end
                        PH_LOW: begin
                            n_cnt = cnt_inc;
                            if (cnt_inc >= {8'd0, low_lim}) begin
                                n_cnt   = '0;
                                n_phase = PH_HIGH;
                                if (r_bit == 3'd0) begin
                                    n_bit = BIT_FIRST;
                                    if (r_color == COL_BLUE) begin
                                        n_color = COL_GREEN;
                                        if (last_led) begin
                                            // last byte sent, hold low to latch
                                            n_phase   = PH_LATCH;
                                            n_led_ptr = '0;
                                        end else begin
                                            n_led_ptr = r_led_ptr + LED_W'(1);
                                        end
                                    end else begin
                                        n_color = r_color + 2'd1;
                                    end
                                end else begin
                                    n_bit = r_bit - 3'd1;
                                end
                            end
                        end
                        PH_LATCH: begin
                            n_cnt = cnt_inc;
                            if (cnt_inc >= r_latch) begin
                                n_done    = 1'b1;
                                n_phase   = PH_IDLE;
                                n_cnt     = '0;
                                n_led_ptr = '0;
                                n_color   = COL_GREEN;
                                n_bit     = BIT_FIRST;
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    if (r_kind < KIND_TICK && busy_now) begin
                        n_status = ST_BUSY;
                    end else begin
                        case (r_kind)
                            KIND_SET_ONE: begin
                                if (!led_ok) begin
                                    n_status = ST_RANGE;
                                end else begin
                                    store_cmd.wr_en = 1'b1;
                                    store_cmd.addr  = r_led[LED_W-1:0];
                                    store_cmd.wdata = {r_green, r_red, r_blue};
                                end
                            end
                            KIND_SET_ALL: begin
                                store_cmd.fill_en = 1'b1;
                                store_cmd.wdata   = {r_green, r_red, r_blue};
                            end
                            KIND_CLEAR: begin
                                store_cmd.fill_en = 1'b1;
                            end
                            KIND_SHOW: begin
                                n_phase   = PH_HIGH;
                                n_cnt     = '0;
                                n_led_ptr = '0;
                                n_color   = COL_GREEN;
                                n_bit     = BIT_FIRST;
                            end
                            default: ;
                        endcase
                    end
                    n_line     = n_phase == PH_HIGH;
                    n_busy_res = n_phase != PH_IDLE;
                end
            end
            default: n_ctl = CTL_IDLE;
        endcase
    end

    assign busy         = r_ctl == CTL_EXEC;
    assign o_valid      = r_valid;
    assign o_data_line  = r_line;
    assign o_busy_res   = r_busy_res;
    assign o_frame_done = r_done;
    assign o_status     = r_status;

endmodule

`default_nettype wire

// File: sv/alfs_store.sv
// pixel store: one green-red-blue row per led, with a fill value for unwritten rows
`default_nettype none

module alfs_store
    import alfs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_store_cmd       i_cmd,
    input  wire logic [LED_W-1:0] i_rd_addr,
    output t_grb                  o_rd_data
);

    t_grb                 r_mem [LED_COUNT];
    t_grb                 r_rd_data;
    logic                 r_rd_vld;
    logic [LED_COUNT-1:0] r_vld;
    t_grb                 r_fill;

    // row memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_vld  <= r_vld[i_rd_addr];
    end

    // set all and clear only swap the fill value and drop every row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_fill <= '0;
        end else if (i_cmd.fill_en) begin
            r_vld  <= '0;
            r_fill <= i_cmd.wdata;
        end else if (i_cmd.wr_en) begin
            r_vld[i_cmd.addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : r_fill;

endmodule

`default_nettype wire
